>>> hw/rtl/pwmcap_pkg.sv
// Shared constants, types and the microcode table of the PWM period/duty capture block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pwmcap_pkg;

    // Timer and field widths
    localparam int CNT_BITS  = 16;
    localparam int CAP_W     = 16;
    localparam int OVF_W     = 16;
    localparam int TIME_W    = 32;
    localparam int TICK_W    = 24;
    localparam int DUTY_W    = 7;
    localparam int FREQ_W    = 24;

    localparam logic [CAP_W-1:0]  CAP_MASK   = (CNT_BITS >= CAP_W) ? {CAP_W{1'b1}} :
                                               CAP_W'((33'd1 << CNT_BITS) - 33'd1);
    localparam logic [OVF_W-1:0]  OVF_MAX    = {OVF_W{1'b1}};
    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000000);
    localparam logic [DUTY_W-1:0] DUTY_SCALE = DUTY_W'(100);

    // Quotient bits per division pass
    localparam int DUTY_STEPS = DUTY_W;
    localparam int FREQ_STEPS = FREQ_W;
    localparam int STEP_W     = $clog2(FREQ_STEPS);

    // Event kinds
    localparam logic EVT_CAPTURE  = 1'b0;
    localparam logic EVT_OVERFLOW = 1'b1;

    // Capture phase
    typedef enum logic [1:0] {
        PH_RISE1 = 2'd0,
        PH_FALL  = 2'd1,
        PH_RISE2 = 2'd2
    } phase_t;

    // Datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_EXEC,
        OP_LOAD_DUTY,
        OP_DIV_STEP,
        OP_LOAD_FREQ,
        OP_SAVE_FREQ,
        OP_EMIT
    } op_t;

    // Condition that holds the step counter in place
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN_EMPTY,
        HOLD_OUT_BUSY
    } hold_t;

    // Condition that takes the jump target instead of the next step
    typedef enum logic [1:0] {
        BR_NONE,
        BR_ALWAYS,
        BR_NO_DIV,
        BR_CNT_NZ
    } br_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_FETCH     = 3'd0;
    localparam upc_t UPC_EXEC      = 3'd1;
    localparam upc_t UPC_LOAD_DUTY = 3'd2;
    localparam upc_t UPC_DIV_DUTY  = 3'd3;
    localparam upc_t UPC_LOAD_FREQ = 3'd4;
    localparam upc_t UPC_DIV_FREQ  = 3'd5;
    localparam upc_t UPC_SAVE_FREQ = 3'd6;
    localparam upc_t UPC_EMIT      = 3'd7;

    typedef struct packed {
        op_t   op;
        hold_t hold;
        br_t   br;
        upc_t  target;
    } ucode_t;

    // Control program: one word per step
    function automatic ucode_t ucode_rom(upc_t pc);
        ucode_t w;
        unique case (pc)
            UPC_FETCH:     w = '{OP_NOP,       HOLD_IN_EMPTY, BR_NONE,   UPC_FETCH};
            UPC_EXEC:      w = '{OP_EXEC,      HOLD_NONE,     BR_NO_DIV, UPC_EMIT};
            UPC_LOAD_DUTY: w = '{OP_LOAD_DUTY, HOLD_NONE,     BR_NONE,   UPC_FETCH};
            UPC_DIV_DUTY:  w = '{OP_DIV_STEP,  HOLD_NONE,     BR_CNT_NZ, UPC_DIV_DUTY};
            UPC_LOAD_FREQ: w = '{OP_LOAD_FREQ, HOLD_NONE,     BR_NONE,   UPC_FETCH};
            UPC_DIV_FREQ:  w = '{OP_DIV_STEP,  HOLD_NONE,     BR_CNT_NZ, UPC_DIV_FREQ};
            UPC_SAVE_FREQ: w = '{OP_SAVE_FREQ, HOLD_NONE,     BR_NONE,   UPC_FETCH};
            UPC_EMIT:      w = '{OP_EMIT,      HOLD_OUT_BUSY, BR_ALWAYS, UPC_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pwmcap_if.sv
// Valid/ready channel interfaces for timer events in and measurement results out.
// Depends on pwmcap_pkg for field widths.
`default_nettype none

interface pwmcap_evt_if;
    import pwmcap_pkg::*;

    logic             valid;
    logic             ready;
    logic             event_kind;
    logic [CAP_W-1:0] capture_value;

    modport source (output valid, output event_kind, output capture_value, input ready);
    modport sink   (input valid, input event_kind, input capture_value, output ready);
endinterface

interface pwmcap_res_if;
    import pwmcap_pkg::*;

    logic              valid;
    logic              ready;
    logic              done_res;
    logic [DUTY_W-1:0] duty_percent;
    logic [FREQ_W-1:0] frequency_hz;
    logic              arm_rising;
    logic              error;

    modport source (output valid, output done_res, output duty_percent,
                    output frequency_hz, output arm_rising, output error, input ready);
    modport sink   (input valid, input done_res, input duty_percent,
                    input frequency_hz, input arm_rising, input error, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pwm_period_duty_capture.sv
// Top level of the PWM period/duty capture block: microcoded sequencer and datapath.
// Depends on pwmcap_pkg and the channel interfaces in pwmcap_if.sv.
//
// Usage:
//   evt (sink): one request per timer event, a capture of the 16-bit counter or an
//   overflow. res (source): exactly one result request per event, in order.
//   cfg_we/cfg_wdata write the tick rate used as frequency dividend; write it only
//   while the block is idle.
// Processing:
//   An event that completes no measurement, or one in error, passes through fetch, execute and emit.
//   The third capture of a period, unless in error, runs two restoring divisions on
//   one shared subtract/compare unit, 7 steps for duty and 24 for frequency, one
//   quotient bit per cycle, plus load and save steps of the microcode program.
//   One event is processed at a time; evt.ready is high only in the fetch step.
// Reset:
//   Phase returns to awaiting the first rising edge, the overflow count and the
//   stored times clear, the tick rate returns to 1000000, no result is pending.
// Stall:
//   A result sits in the output register until res.ready; the emit step holds
//   while that register is occupied, so no further event is taken meanwhile.
`default_nettype none

module pwm_period_duty_capture (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    pwmcap_evt_if.sink                        evt,
    pwmcap_res_if.source                      res,
    input  wire logic                         cfg_we,
    input  wire logic [pwmcap_pkg::TICK_W-1:0] cfg_wdata
);
    import pwmcap_pkg::*;

    // Sequencer
    upc_t   pc_reg, pc_next;
    ucode_t uw;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    // Measurement state
    phase_t            phase_reg, phase_next;
    logic [OVF_W-1:0]  ovf_reg, ovf_next;
    logic [TIME_W-1:0] first_reg, first_next;
    logic [TIME_W-1:0] fall_reg, fall_next;
    logic [TICK_W-1:0] tick_reg, tick_next;

    // Latched event
    logic              kind_reg, kind_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;

    // Divider datapath
    logic [TIME_W-1:0] on_reg, on_next;
    logic [TIME_W-1:0] total_reg, total_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0] dvd_reg, dvd_next;
    logic [FREQ_W-1:0] quot_reg, quot_next;

    // Result fields under construction
    logic              done_reg, done_next;
    logic              err_reg, err_next;
    logic              arm_reg, arm_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic              out_done_reg, out_done_next;
    logic              out_err_reg, out_err_next;
    logic              out_arm_reg, out_arm_next;
    logic [DUTY_W-1:0] out_duty_reg, out_duty_next;
    logic [FREQ_W-1:0] out_freq_reg, out_freq_next;

    // Combinational helpers
    logic [TIME_W-1:0]   ext_time;
    logic                complete;
    logic                bad;
    logic                hold;
    logic                branch;
    logic                out_free;
    logic [TIME_W:0]     rem_sh;
    logic [TIME_W+1:0]   diff;
    logic                fits;
    logic [TIME_W+DUTY_W-1:0] prod;

    // Capture extended by the overflow count, wrapped to 32 bits
    function automatic logic [TIME_W-1:0] extend_time(logic [OVF_W-1:0] ovf,
                                                       logic [CAP_W-1:0] cap);
        logic [OVF_W+TIME_W-1:0] wide;
        wide = ((OVF_W+TIME_W)'(ovf) << CNT_BITS) + (OVF_W+TIME_W)'(cap & CAP_MASK);
        return wide[TIME_W-1:0];
    endfunction

    assign uw       = ucode_rom(pc_reg);
    assign evt.ready = (uw.hold == HOLD_IN_EMPTY);
    assign out_free = !out_valid_reg || res.ready;

    assign ext_time = extend_time(ovf_reg, cap_reg);
    assign complete = (kind_reg == EVT_CAPTURE) && (phase_reg == PH_RISE2);
    assign bad      = (ovf_reg >= OVF_MAX) || (fall_reg < first_reg) ||
                      (ext_time < fall_reg) || (ext_time == first_reg);

    // One restoring division step: shift in a dividend bit, try subtract
    assign rem_sh = {rem_reg, dvd_reg[FREQ_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, total_reg};
    assign fits   = !diff[TIME_W+1];

    // on * 100; top bits seed the remainder, low bits are shifted in
    assign prod = (TIME_W+DUTY_W)'(on_reg) * (TIME_W+DUTY_W)'(DUTY_SCALE);

    // Sequencer control: hold, branch or advance
    always_comb
    begin
        unique case (uw.hold)
            HOLD_IN_EMPTY: hold = !evt.valid;
            HOLD_OUT_BUSY: hold = !out_free;
            default:       hold = 1'b0;
        endcase
        unique case (uw.br)
            BR_ALWAYS: branch = 1'b1;
            BR_NO_DIV: branch = !(complete && !bad);
            BR_CNT_NZ: branch = (cnt_reg != '0);
            default:   branch = 1'b0;
        endcase
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (branch)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + upc_t'(1);
        end
    end

    // Datapath driven by the control word
    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        ovf_next   = ovf_reg;
        first_next = first_reg;
        fall_next  = fall_reg;
        kind_next  = kind_reg;
        cap_next   = cap_reg;
        on_next    = on_reg;
        total_next = total_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        done_next  = done_reg;
        err_next   = err_reg;
        arm_next   = arm_reg;
        duty_next  = duty_reg;
        freq_next  = freq_reg;

        out_valid_next = out_valid_reg;
        out_done_next  = out_done_reg;
        out_err_next   = out_err_reg;
        out_arm_next   = out_arm_reg;
        out_duty_next  = out_duty_reg;
        out_freq_next  = out_freq_reg;

        // Drop a result once the receiver takes it
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Config register write
        tick_next = cfg_we ? cfg_wdata : tick_reg;

        // Latch the event on acceptance
        if (evt.valid && evt.ready)
        begin
            kind_next = evt.event_kind;
            cap_next  = evt.capture_value;
        end

        unique case (uw.op)
            OP_NOP:
            begin
            end
            OP_EXEC:
            begin
                done_next = 1'b0;
                err_next  = 1'b0;
                duty_next = '0;
                freq_next = '0;
                if (kind_reg == EVT_OVERFLOW)
                begin
                    if (ovf_reg < OVF_MAX)
                    begin
                        ovf_next = ovf_reg + OVF_W'(1);
                    end
                    phase_next = (phase_reg == PH_FALL || phase_reg == PH_RISE2) ?
                                 phase_reg : PH_RISE1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_FALL:
                        begin
                            fall_next  = ext_time;
                            phase_next = PH_RISE2;
                        end
                        PH_RISE2:
                        begin
                            done_next  = 1'b1;
                            err_next   = bad;
                            on_next    = fall_reg - first_reg;
                            total_next = ext_time - first_reg;
                            ovf_next   = '0;
                            phase_next = PH_RISE1;
                        end
                        default:
                        begin
                            first_next = ext_time;
                            phase_next = PH_FALL;
                        end
                    endcase
                end
                arm_next = (phase_next != PH_FALL);
            end
            OP_LOAD_DUTY:
            begin
                rem_next  = prod[TIME_W+DUTY_W-1:DUTY_W];
                dvd_next  = {prod[DUTY_W-1:0], (FREQ_W-DUTY_W)'(0)};
                quot_next = '0;
                cnt_next  = STEP_W'(DUTY_STEPS - 1);
            end
            OP_DIV_STEP:
            begin
                rem_next  = fits ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
                dvd_next  = {dvd_reg[FREQ_W-2:0], 1'b0};
                quot_next = {quot_reg[FREQ_W-2:0], fits};
                cnt_next  = cnt_reg - STEP_W'(1);
            end
            OP_LOAD_FREQ:
            begin
                duty_next = quot_reg[DUTY_W-1:0];
                rem_next  = '0;
                dvd_next  = tick_reg;
                quot_next = '0;
                cnt_next  = STEP_W'(FREQ_STEPS - 1);
            end
            OP_SAVE_FREQ:
            begin
                freq_next = quot_reg;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = done_reg;
                    out_err_next   = err_reg;
                    out_arm_next   = arm_reg;
                    out_duty_next  = duty_reg;
                    out_freq_next  = freq_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= UPC_FETCH;
            cnt_reg       <= '0;
            phase_reg     <= PH_RISE1;
            ovf_reg       <= '0;
            first_reg     <= '0;
            fall_reg      <= '0;
            tick_reg      <= TICK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            ovf_reg       <= ovf_next;
            first_reg     <= first_next;
            fall_reg      <= fall_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        cap_reg      <= cap_next;
        on_reg       <= on_next;
        total_reg    <= total_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quot_reg     <= quot_next;
        done_reg     <= done_next;
        err_reg      <= err_next;
        arm_reg      <= arm_next;
        duty_reg     <= duty_next;
        freq_reg     <= freq_next;
        out_done_reg <= out_done_next;
        out_err_reg  <= out_err_next;
        out_arm_reg  <= out_arm_next;
        out_duty_reg <= out_duty_next;
        out_freq_reg <= out_freq_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.done_res     = out_done_reg;
    assign res.duty_percent = out_duty_reg;
    assign res.frequency_hz = out_freq_reg;
    assign res.arm_rising   = out_arm_reg;
    assign res.error        = out_err_reg;

endmodule

`default_nettype wire
